// File: src/assert_macros.svh
// Assertion macros used by the top RTL file of the strided array address block.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define SAB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sab assertion failed");

// Check a consequent in the cycle after its antecedent
`define SAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sab assertion failed");

`endif

// File: src/sab_pkg.sv
// Shared types and constants of the strided array address block.
// No dependencies; every other file but the assertion macros uses it.
package sab_pkg;

  localparam int unsigned MAX_DIMS  = 3;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned EB_W      = 16;
  localparam int unsigned EXT_W     = 16;
  localparam int unsigned STR_W     = 24;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned OFF_W     = 47;
  localparam int unsigned DISP_W    = 62;
  localparam int unsigned WGT_W     = STR_W + EB_W;   // stride times element length
  localparam int unsigned PROD_W    = WGT_W + EXT_W;  // coordinate times weight
  localparam int unsigned CNT_W     = 31;             // element count below 2^31
  localparam int unsigned P01_W     = 2 * EXT_W;
  localparam int unsigned P012_W    = 3 * EXT_W;

  localparam logic [P012_W-1:0] CNT_MAX = P012_W'(32'h7FFF_FFFF);

  // Pipelined divider: quotient of CNT_W bits, 2 bits per stage
  localparam int unsigned IDX_W   = CNT_W;
  localparam int unsigned DIV_DW  = 16;
  localparam int unsigned DIV_BPS = 2;
  localparam int unsigned DIV_NS  = (IDX_W + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned DIV_NW  = DIV_NS * DIV_BPS;
  localparam int unsigned DIV_PAD = DIV_NW - IDX_W;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DESC = 2'd1,
    ST_RANGE    = 2'd2,
    ST_COUNT    = 2'd3
  } sab_status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RANK    = 3'd0,
    REG_ELEM    = 3'd1,
    REG_EXT0    = 3'd2,
    REG_EXT1    = 3'd3,
    REG_EXT2    = 3'd4,
    REG_STR0    = 3'd5,
    REG_STR1    = 3'd6,
    REG_STR2    = 3'd7
  } sab_reg_e;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [EB_W-1:0]   elem_bytes;
    logic [EXT_W-1:0]  ext0;
    logic [EXT_W-1:0]  ext1;
    logic [EXT_W-1:0]  ext2;
    logic [STR_W-1:0]  str0;
    logic [STR_W-1:0]  str1;
    logic [STR_W-1:0]  str2;
  } sab_cfg_t;

  // Values derived from the descriptor
  typedef struct packed {
    logic              valid;
    logic              contig;
    logic              count_ov;
    logic [CNT_W-1:0]  total;
    logic [OFF_W-1:0]  size_bytes;
    logic [EXT_W-1:0]  ext0;
    logic [EXT_W-1:0]  ext1;
    logic [WGT_W-1:0]  w0;
    logic [WGT_W-1:0]  w1;
    logic [WGT_W-1:0]  w2;
  } sab_desc_t;

  // Per item status carried after the range check
  typedef struct packed {
    sab_status_e       status;
    logic              zero;
    logic [EB_W-1:0]   byte_in_elem;
  } sab_fix_t;

  typedef struct packed {
    sab_fix_t          fix;
    logic [EXT_W-1:0]  c0;
  } sab_crd_t;

endpackage

// File: src/sab_if.sv
// Valid/ready channel interfaces for offsets in and addresses out.
// Widths come from sab_pkg.
interface sab_in_if;
  logic                         valid;
  logic                         ready;
  logic [sab_pkg::OFF_W-1:0]    logical_offset;

  modport source (output valid, output logical_offset, input ready);
  modport sink   (input valid, input logical_offset, output ready);
endinterface

interface sab_out_if;
  logic                         valid;
  logic                         ready;
  logic [sab_pkg::DISP_W-1:0]   byte_displacement;
  logic [1:0]                   status;
  logic                         is_contiguous;

  modport source (output valid, output byte_displacement, output status,
                  output is_contiguous, input ready);
  modport sink   (input valid, input byte_displacement, input status,
                  input is_contiguous, output ready);
endinterface

// File: src/sab_desc.sv
// Descriptor unit: derives validity, element count, total bytes, weights and
// contiguity from the configuration registers over five register stages.
module sab_desc (
  input  logic               clk_i,
  input  sab_pkg::sab_cfg_t  cfg_i,
  output sab_pkg::sab_desc_t desc_o
);
  import sab_pkg::*;

  logic              used0, used1, used2;
  logic [EXT_W-1:0]  e0_d, e1_d, e2_d;
  logic [EXT_W-1:0]  e0_q, e1_q, e2_q, e2b_q;
  logic [WGT_W-1:0]  w0_q, w1_q, w2_q;
  logic              va_q, bad0_q, bad1_q, z0_q, z1_q, used2_q;
  logic [STR_W-1:0]  str2_q;
  logic [P01_W-1:0]  p01_d, p01_q;
  logic              bad2_d;
  logic              vb_q, contig_q, zlo_q, z2_q;
  logic [P012_W-1:0] p012_q;
  logic              ov01_q, zlo_c_q, z2_c_q;
  logic              zero_total;
  logic              cov_q;
  logic [CNT_W-1:0]  total_q;
  logic [OFF_W-1:0]  tb_q;

  // Unused dimensions behave as extent one
  assign used0 = cfg_i.rank > RANK_W'(0);
  assign used1 = cfg_i.rank > RANK_W'(1);
  assign used2 = cfg_i.rank > RANK_W'(2);
  assign e0_d  = used0 ? cfg_i.ext0 : EXT_W'(1);
  assign e1_d  = used1 ? cfg_i.ext1 : EXT_W'(1);
  assign e2_d  = used2 ? cfg_i.ext2 : EXT_W'(1);

  // Stage A: effective extents, weights, validity, low dimension checks
  always_ff @(posedge clk_i) begin
    e0_q    <= e0_d;
    e1_q    <= e1_d;
    e2_q    <= e2_d;
    w0_q    <= WGT_W'(cfg_i.str0) * WGT_W'(cfg_i.elem_bytes);
    w1_q    <= WGT_W'(cfg_i.str1) * WGT_W'(cfg_i.elem_bytes);
    w2_q    <= WGT_W'(cfg_i.str2) * WGT_W'(cfg_i.elem_bytes);
    va_q    <= (cfg_i.rank <= RANK_W'(MAX_DIMS)) && (cfg_i.elem_bytes != '0)
               && !(used0 && cfg_i.str0 == '0) && !(used1 && cfg_i.str1 == '0)
               && !(used2 && cfg_i.str2 == '0);
    bad0_q  <= used0 && (cfg_i.ext0 > EXT_W'(1)) && (cfg_i.str0 != STR_W'(1));
    bad1_q  <= used1 && (cfg_i.ext1 > EXT_W'(1)) && (cfg_i.str1 != STR_W'(cfg_i.ext0));
    z0_q    <= used0 && (cfg_i.ext0 == '0);
    z1_q    <= used1 && (cfg_i.ext1 == '0);
    used2_q <= used2;
    str2_q  <= cfg_i.str2;
  end

  // Stage B: product of the two lower extents and the contiguity flag
  assign p01_d  = P01_W'(e0_q) * P01_W'(e1_q);
  assign bad2_d = used2_q && (e2_q > EXT_W'(1)) && (P01_W'(str2_q) != p01_d);

  always_ff @(posedge clk_i) begin
    p01_q    <= p01_d;
    e2b_q    <= e2_q;
    vb_q     <= va_q;
    contig_q <= va_q && !(bad0_q || (!z0_q && bad1_q) || (!z0_q && !z1_q && bad2_d));
    zlo_q    <= z0_q || z1_q;
    z2_q     <= e2_q == '0;
  end

  // Stage C: full product and the early overflow check
  always_ff @(posedge clk_i) begin
    p012_q  <= P012_W'(p01_q) * P012_W'(e2b_q);
    ov01_q  <= P012_W'(p01_q) > CNT_MAX;
    zlo_c_q <= zlo_q;
    z2_c_q  <= z2_q;
  end

  // Stage D: element count; a zero extent met before overflow empties the array
  assign zero_total = zlo_c_q || (z2_c_q && !ov01_q);

  always_ff @(posedge clk_i) begin
    cov_q   <= !zero_total && (ov01_q || p012_q > CNT_MAX);
    total_q <= zero_total ? '0 : p012_q[CNT_W-1:0];
  end

  // Stage E: total size in bytes
  always_ff @(posedge clk_i) begin
    tb_q <= OFF_W'(total_q) * OFF_W'(cfg_i.elem_bytes);
  end

  assign desc_o = '{valid:       vb_q,
                    contig:      contig_q,
                    count_ov:    cov_q,
                    total:       total_q,
                    size_bytes:  tb_q,
                    ext0:        e0_q,
                    ext1:        e1_q,
                    w0:          w0_q,
                    w1:          w1_q,
                    w2:          w2_q};

endmodule

// File: src/sab_div.sv
// Pipelined restoring divider: DIV_BPS quotient bits per register stage.
// Users hold the divisor static with items in flight; unchecked. Uses sab_pkg.
module sab_div #(
  parameter int unsigned SW = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         vld_i,
  input  logic [sab_pkg::DIV_DW-1:0]   rem_i,
  input  logic [sab_pkg::IDX_W-1:0]    num_i,
  input  logic [sab_pkg::DIV_DW-1:0]   divisor_i,
  input  logic [SW-1:0]                side_i,
  output logic                         vld_o,
  output logic [sab_pkg::IDX_W-1:0]    quo_o,
  output logic [sab_pkg::DIV_DW-1:0]   rem_o,
  output logic [SW-1:0]                side_o
);
  import sab_pkg::*;

  logic [DIV_DW-1:0] r_in  [DIV_NS];
  logic [DIV_NW-1:0] n_in  [DIV_NS];
  logic [DIV_DW-1:0] rem_d [DIV_NS];
  logic [DIV_NW-1:0] num_d [DIV_NS];
  logic [DIV_DW-1:0] rem_q [DIV_NS];
  logic [DIV_NW-1:0] num_q [DIV_NS];
  logic [SW-1:0]     side_q [DIV_NS];
  logic [DIV_NS-1:0] vld_q;

  // Stage inputs: the first stage takes the new operands
  always_comb begin
    r_in[0] = rem_i >> DIV_PAD;
    n_in[0] = {rem_i[DIV_PAD-1:0], num_i};
    for (int s = 1; s < DIV_NS; s++) begin
      r_in[s] = rem_q[s-1];
      n_in[s] = num_q[s-1];
    end
  end

  // Shift-subtract steps of each stage; quotient bits shift in at the bottom
  always_comb begin
    logic [DIV_DW:0]   t;
    logic [DIV_DW-1:0] r;
    logic [DIV_NW-1:0] n;
    for (int s = 0; s < DIV_NS; s++) begin
      r = r_in[s];
      n = n_in[s];
      for (int b = 0; b < DIV_BPS; b++) begin
        t = {r, n[DIV_NW-1]};
        n = {n[DIV_NW-2:0], 1'b0};
        if (t >= {1'b0, divisor_i}) begin
          t    = t - {1'b0, divisor_i};
          n[0] = 1'b1;
        end
        r = t[DIV_DW-1:0];
      end
      rem_d[s] = r;
      num_d[s] = n;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DIV_NS-2:0], vld_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s < DIV_NS; s++) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
      end
      for (int s = 1; s < DIV_NS; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[DIV_NS-1];
  assign quo_o  = num_q[DIV_NS-1][IDX_W-1:0];
  assign rem_o  = rem_q[DIV_NS-1];
  assign side_o = side_q[DIV_NS-1];

endmodule

// File: src/sab_disp.sv
// Displacement unit: weights each coordinate and sums, two register stages.
// Depends on sab_pkg.
module sab_disp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        vld_i,
  input  logic [sab_pkg::EXT_W-1:0]   c0_i,
  input  logic [sab_pkg::EXT_W-1:0]   c1_i,
  input  logic [sab_pkg::EXT_W-1:0]   c2_i,
  input  sab_pkg::sab_fix_t           fix_i,
  input  sab_pkg::sab_desc_t          desc_i,
  output logic                        vld_o,
  output logic [sab_pkg::DISP_W-1:0]  disp_o,
  output sab_pkg::sab_status_e        status_o
);
  import sab_pkg::*;

  logic              pv_q, sv_q;
  logic [PROD_W-1:0] p0_q, p1_q, p2_q;
  sab_fix_t          pfix_q;
  logic [DISP_W-1:0] disp_q;
  sab_status_e       st_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (adv_i) begin
      pv_q <= vld_i;
      sv_q <= pv_q;
    end
  end

  // Weight each coordinate
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p0_q   <= PROD_W'(c0_i) * PROD_W'(desc_i.w0);
      p1_q   <= PROD_W'(c1_i) * PROD_W'(desc_i.w1);
      p2_q   <= PROD_W'(c2_i) * PROD_W'(desc_i.w2);
      pfix_q <= fix_i;
    end
  end

  // Sum and drop the displacement on error or empty array
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      disp_q <= pfix_q.zero ? '0
              : DISP_W'(p0_q) + DISP_W'(p1_q) + DISP_W'(p2_q)
                + DISP_W'(pfix_q.byte_in_elem);
      st_q   <= pfix_q.status;
    end
  end

  assign vld_o    = sv_q;
  assign disp_o   = disp_q;
  assign status_o = st_q;

endmodule

// File: src/strided_array_byte_address.sv
// Channel     Dir  Payload
// in_ch       in   logical_offset[46:0]
// out_ch      out  byte_displacement[61:0], status[1:0], is_contiguous
// cfg_*       in   write enable, register index[2:0], data[23:0]
// One offset is taken per cycle while the pipeline is not stalled; its result
// reaches the output through 52 register stages: three 16-stage dividers
// (element length, extent 0, extent 1), a range stage, two multiply-add stages
// and the output register. Descriptor values settle through the descriptor
// unit's register stages after a register write. A stall holds every stage
// in place; input ready follows the output register (empty or being taken).
// Reset clears the valid bits and resets the descriptor registers.
module strided_array_byte_address (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sab_in_if.sink                            in_ch,
  sab_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [sab_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sab_pkg::CFG_W-1:0]         cfg_data_i
);
  import sab_pkg::*;

  `include "assert_macros.svh"

  sab_cfg_t          cfg_q;
  sab_desc_t         desc;
  logic              adv;

  logic              d1_vld;
  logic [IDX_W-1:0]  d1_quo;
  logic [DIV_DW-1:0] d1_rem;
  logic [OFF_W-1:0]  d1_off;

  sab_status_e       fix_st;
  logic              fix_eq;
  sab_fix_t          fix_d, fix_q;
  logic [IDX_W-1:0]  idx_d, idx_q;
  logic              fix_vld_q;

  logic              d2_vld;
  logic [IDX_W-1:0]  d2_quo;
  logic [DIV_DW-1:0] d2_rem;
  logic [$bits(sab_fix_t)-1:0] d2_side;
  sab_crd_t          crd_in, crd_out;
  logic              d3_vld;
  logic [IDX_W-1:0]  d3_quo;
  logic [DIV_DW-1:0] d3_rem;
  logic [$bits(sab_crd_t)-1:0] d3_side;

  logic              disp_vld;
  logic [DISP_W-1:0] disp;
  sab_status_e       disp_st;

  logic              out_vld_q, out_contig_q;
  logic [DISP_W-1:0] out_disp_q;
  sab_status_e       out_st_q;

  // Write descriptor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rank: '0, elem_bytes: EB_W'(1), ext0: '0, ext1: '0, ext2: '0,
                 str0: STR_W'(1), str1: STR_W'(1), str2: STR_W'(1)};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RANK: cfg_q.rank       <= cfg_data_i[RANK_W-1:0];
        REG_ELEM: cfg_q.elem_bytes <= cfg_data_i[EB_W-1:0];
        REG_EXT0: cfg_q.ext0       <= cfg_data_i[EXT_W-1:0];
        REG_EXT1: cfg_q.ext1       <= cfg_data_i[EXT_W-1:0];
        REG_EXT2: cfg_q.ext2       <= cfg_data_i[EXT_W-1:0];
        REG_STR0: cfg_q.str0       <= cfg_data_i;
        REG_STR1: cfg_q.str1       <= cfg_data_i;
        REG_STR2: cfg_q.str2       <= cfg_data_i;
        default:  cfg_q            <= cfg_q;
      endcase
    end
  end

  sab_desc u_desc (
    .clk_i  (clk_i),
    .cfg_i  (cfg_q),
    .desc_o (desc)
  );

  // Whole pipeline moves when the output register can take a transfer
  assign adv         = !out_vld_q || out_ch.ready;
  assign in_ch.ready = adv;

  // Split offset into element index and byte within element
  sab_div #(.SW(OFF_W)) u_div_elem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (in_ch.valid),
    .rem_i     (in_ch.logical_offset[OFF_W-1:IDX_W]),
    .num_i     (in_ch.logical_offset[IDX_W-1:0]),
    .divisor_i (cfg_q.elem_bytes),
    .side_i    (in_ch.logical_offset),
    .vld_o     (d1_vld),
    .quo_o     (d1_quo),
    .rem_o     (d1_rem),
    .side_o    (d1_off)
  );

  // Status, range check, and the one-past-the-end case
  always_comb begin
    if (!desc.valid) begin
      fix_st = ST_BAD_DESC;
    end else if (desc.count_ov) begin
      fix_st = ST_COUNT;
    end else if (d1_off > desc.size_bytes) begin
      fix_st = ST_RANGE;
    end else begin
      fix_st = ST_OK;
    end
    fix_eq = d1_quo == desc.total;
    idx_d  = fix_eq ? desc.total - IDX_W'(1) : d1_quo;
    fix_d  = '{status:       fix_st,
               zero:         (fix_st != ST_OK) || (desc.total == '0),
               byte_in_elem: fix_eq ? cfg_q.elem_bytes : d1_rem};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_vld_q <= 1'b0;
    end else if (adv) begin
      fix_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fix_q <= fix_d;
      idx_q <= idx_d;
    end
  end

  // Coordinate 0 and the index above it
  sab_div #(.SW($bits(sab_fix_t))) u_div_dim0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (fix_vld_q),
    .rem_i     ('0),
    .num_i     (idx_q),
    .divisor_i (desc.ext0),
    .side_i    (fix_q),
    .vld_o     (d2_vld),
    .quo_o     (d2_quo),
    .rem_o     (d2_rem),
    .side_o    (d2_side)
  );

  assign crd_in = '{fix: sab_fix_t'(d2_side), c0: d2_rem};

  // Coordinates 1 and 2
  sab_div #(.SW($bits(sab_crd_t))) u_div_dim1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (d2_vld),
    .rem_i     ('0),
    .num_i     (d2_quo),
    .divisor_i (desc.ext1),
    .side_i    (crd_in),
    .vld_o     (d3_vld),
    .quo_o     (d3_quo),
    .rem_o     (d3_rem),
    .side_o    (d3_side)
  );

  assign crd_out = sab_crd_t'(d3_side);

  sab_disp u_disp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (d3_vld),
    .c0_i     (crd_out.c0),
    .c1_i     (d3_rem),
    .c2_i     (d3_quo[EXT_W-1:0]),
    .fix_i    (crd_out.fix),
    .desc_i   (desc),
    .vld_o    (disp_vld),
    .disp_o   (disp),
    .status_o (disp_st)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= disp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_disp_q   <= disp;
      out_st_q     <= disp_st;
      out_contig_q <= desc.contig;
    end
  end

  assign out_ch.valid             = out_vld_q;
  assign out_ch.byte_displacement = out_disp_q;
  assign out_ch.status            = out_st_q;
  assign out_ch.is_contiguous     = out_contig_q;

  `SAB_ASSERT_NOW(a_err_zero_disp, out_vld_q && out_st_q != ST_OK, out_disp_q == '0)
  `SAB_ASSERT_NOW(a_bad_not_contig, out_vld_q && out_st_q == ST_BAD_DESC, !out_contig_q)
  `SAB_ASSERT_NOW(a_ready_when_empty, !out_vld_q, in_ch.ready)
  `SAB_ASSERT_NEXT(a_drain_empties, out_vld_q && out_ch.ready && !disp_vld, !out_vld_q)

endmodule
